// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the allocator unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fpa_pkg.sv =====
// types and constants of the fixed partition allocator
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int OPCODE_W  = 1;
   localparam int IDX_W     = 6;
   localparam int SIZE_W    = 24;
   localparam int STATUS_W  = 2;
   localparam int FRAG_W    = 30;
   localparam int POLICY_W  = 2;
   localparam int COUNT_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LOAD_DONE = 2'd3;

   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLE_COUNT = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_RESET = POL_FIRST;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd64;
   localparam logic [FRAG_W-1:0]   FRAG_MAX     = '1;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_COMMIT,
      FSM_FINISH
   } fpa_state_type;

endpackage

// ===== hw/rtl/fpa_if.sv =====
// request and response channel interfaces of the allocator
`timescale 1ns / 1ps

interface fpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [fpa_pkg::OPCODE_W-1:0]  opcode;
   logic [fpa_pkg::IDX_W-1:0]     load_index;
   logic [fpa_pkg::SIZE_W-1:0]    size_value;

   modport source (output valid, opcode, load_index, size_value, input ready);
   modport sink (input valid, opcode, load_index, size_value, output ready);
endinterface

interface fpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fpa_pkg::STATUS_W-1:0]  status;
   logic [fpa_pkg::IDX_W-1:0]     chosen_index;
   logic [fpa_pkg::SIZE_W-1:0]    chosen_size;
   logic [fpa_pkg::FRAG_W-1:0]    frag_amount;

   modport source (output valid, status, chosen_index, chosen_size, frag_amount,
                   input ready);
   modport sink (input valid, status, chosen_index, chosen_size, frag_amount,
                 output ready);
endinterface

// ===== hw/rtl/fixed_partition_allocator_unit.sv =====
// Fixed partition allocator: a table of holes with first, best or worst fit placement.
// Channels: req_if carries one item (load a hole size, or allocate a request size),
// rsp_if returns exactly one result item per request item, both valid/ready.
// csr_we/csr_index/csr_wdata write policy (index 0) and hole_count (index 1);
// write them only while the block is idle.
// Hole sizes and taken flags share one synchronous memory of MAX_HOLES entries.
// Timing: a load registers its result, which the finish step then hands to the output
// register. An allocate reads one entry per cycle over n = min(hole_count, MAX_HOLES)
// entries, then writes back the chosen hole in the commit step and hands its result
// to the output register in the finish step; the next item is taken only after the
// result is registered. The read port, one entry per cycle, sets the scan time.
// Reset: policy returns to first fit and hole_count to 64; then a clearing pass over
// all MAX_HOLES entries marks every hole free, and no item is accepted during it.
// A stalled receiver holds the result in the output register; the block may take
// and work on one further item meanwhile, and holds that result until the slot frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_partition_allocator_unit #(
   parameter int MAX_HOLES = 64,
   parameter int SIZE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   fpa_req_if.sink                         req_if,
   fpa_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [fpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpa_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import fpa_pkg::*;

   localparam int AW    = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CW    = $clog2(MAX_HOLES + 1);
   localparam int NW    = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int SUM_W = ((SIZE_BITS > FRAG_W) ? SIZE_BITS : FRAG_W) + 1;
   localparam int MW    = SIZE_BITS + 1;

   // hole table: taken flag on top of the size
   logic [MW-1:0] hole_mem [MAX_HOLES];

   fpa_state_type        state_ff, state_in;
   logic [POLICY_W-1:0]  policy_ff;
   logic [COUNT_W-1:0]   hole_count_ff;
   logic [SIZE_BITS-1:0] val_ff, val_in;
   logic [NW-1:0]        scan_n_ff, scan_n_in;
   logic [NW-1:0]        issue_ff, issue_in;
   logic [NW-1:0]        clr_ff, clr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_idx_ff;
   logic [MW-1:0]        rd_data_ff;
   logic                 found_ff, found_in;
   logic                 any_free_ff, any_free_in;
   logic [FRAG_W-1:0]    sum_ff, sum_in;
   logic [AW-1:0]        pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_diff_ff, pick_diff_in;
   logic [SIZE_BITS-1:0] pick_size_ff, pick_size_in;

   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_index_ff, res_index_in;
   logic [SIZE_W-1:0]    res_size_ff, res_size_in;
   logic [FRAG_W-1:0]    res_frag_ff, res_frag_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic [FRAG_W-1:0]    rsp_frag_ff, rsp_frag_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [MW-1:0]        mem_wd;
   logic [AW-1:0]        mem_ra;

   logic                 req_fire;
   logic                 out_free;
   logic                 ent_taken;
   logic [SIZE_BITS-1:0] ent_size;
   logic [SUM_W-1:0]     sum_ext;
   logic [FRAG_W-1:0]    sum_sat;
   logic                 ent_fits;
   logic [SIZE_BITS-1:0] ent_diff;
   logic                 ent_better;
   logic [NW-1:0]        count_ext;

   assign req_if.ready       = (state_ff == FSM_IDLE);
   assign req_fire           = req_if.valid && req_if.ready;
   assign out_free           = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.chosen_index = rsp_index_ff;
   assign rsp_if.chosen_size  = rsp_size_ff;
   assign rsp_if.frag_amount  = rsp_frag_ff;

   // scan datapath on the registered memory word
   assign ent_taken  = rd_data_ff[SIZE_BITS];
   assign ent_size   = rd_data_ff[SIZE_BITS-1:0];
   assign sum_ext    = SUM_W'(sum_ff) + SUM_W'(ent_size);
   assign sum_sat    = (sum_ext > SUM_W'(FRAG_MAX)) ? FRAG_MAX : FRAG_W'(sum_ext);
   assign ent_fits   = (ent_size >= val_ff);
   assign ent_diff   = ent_size - val_ff;
   assign ent_better = !found_ff ||
                       ((policy_ff == POL_BEST) && (ent_diff < pick_diff_ff)) ||
                       ((policy_ff == POL_WORST) && (ent_diff > pick_diff_ff));
   assign count_ext  = NW'(hole_count_ff);

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      scan_n_in     = scan_n_ff;
      issue_in      = issue_ff;
      clr_in        = clr_ff;
      rd_vld_in     = 1'b0;
      found_in      = found_ff;
      any_free_in   = any_free_ff;
      sum_in        = sum_ff;
      pick_in       = pick_ff;
      pick_diff_in  = pick_diff_ff;
      pick_size_in  = pick_size_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_size_in   = res_size_ff;
      res_frag_in   = res_frag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_frag_in   = rsp_frag_ff;
      mem_we        = 1'b0;
      mem_wa        = pick_ff;
      mem_wd        = {1'b1, pick_size_ff};
      mem_ra        = issue_ff[AW-1:0];

      // fold in the entry read in the previous cycle
      if (rd_vld_ff && !ent_taken) begin
         any_free_in = 1'b1;
         sum_in      = sum_sat;
         if (ent_fits && ent_better) begin
            found_in     = 1'b1;
            pick_in      = rd_idx_ff;
            pick_diff_in = ent_diff;
            pick_size_in = ent_size;
         end
      end

      unique case (state_ff)
         FSM_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[AW-1:0];
            mem_wd = '0;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(MAX_HOLES - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_fire) begin
               val_in      = SIZE_BITS'(req_if.size_value);
               scan_n_in   = (count_ext > NW'(MAX_HOLES)) ? NW'(MAX_HOLES) : count_ext;
               issue_in    = '0;
               found_in    = 1'b0;
               any_free_in = 1'b0;
               sum_in      = '0;
               pick_in     = '0;
               if (req_if.opcode == OP_LOAD) begin
                  // loads outside the table change nothing
                  mem_we        = (NW'(req_if.load_index) < NW'(MAX_HOLES));
                  mem_wa        = AW'(req_if.load_index);
                  mem_wd        = {1'b0, SIZE_BITS'(req_if.size_value)};
                  res_status_in = ST_LOAD_DONE;
                  res_index_in  = '0;
                  res_size_in   = '0;
                  res_frag_in   = '0;
                  state_in      = FSM_FINISH;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            if (issue_ff < scan_n_ff) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + NW'(1);
            end else if (!rd_vld_ff) begin
               state_in = FSM_COMMIT;
            end
         end
         FSM_COMMIT: begin
            if (found_ff) begin
               mem_we        = 1'b1;
               res_status_in = ST_ALLOCATED;
               res_index_in  = IDX_W'(pick_ff);
               res_size_in   = SIZE_W'(pick_size_ff);
               res_frag_in   = FRAG_W'(pick_diff_ff);
            end else begin
               res_status_in = any_free_ff ? ST_NO_FIT : ST_NO_FREE;
               res_index_in  = '0;
               res_size_in   = '0;
               res_frag_in   = any_free_ff ? sum_ff : '0;
            end
            state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_size_in   = res_size_ff;
               rsp_frag_in   = res_frag_ff;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         any_free_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         any_free_ff  <= any_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_RESET;
         hole_count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:     policy_ff     <= POLICY_W'(csr_wdata);
            CSR_HOLE_COUNT: hole_count_ff <= COUNT_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      scan_n_ff     <= scan_n_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= mem_ra;
      sum_ff        <= sum_in;
      pick_ff       <= pick_in;
      pick_diff_ff  <= pick_diff_in;
      pick_size_ff  <= pick_size_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_size_ff   <= res_size_in;
      res_frag_ff   <= res_frag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_frag_ff   <= rsp_frag_in;
   end

   // one write port and one read port, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hole_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= hole_mem[mem_ra];
   end

   `ASSERT_SYNC(a_pick_is_free_hole, clock, reset, found_ff |-> any_free_ff,
                "chosen hole without any free hole")
   `ASSERT_SYNC(a_pick_fits, clock, reset, found_ff |-> (pick_size_ff >= val_ff),
                "chosen hole smaller than request")
   `ASSERT_SYNC(a_no_read_outside_scan, clock, reset,
                (state_ff == FSM_IDLE) || (state_ff == FSM_FINISH) |-> !rd_vld_ff,
                "table read in flight outside a scan")
   `ASSERT_SYNC(a_result_from_finish, clock, reset,
                $rose(rsp_valid_ff) |-> ($past(state_ff) == FSM_FINISH),
                "result registered outside the finish step")
   `ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_valid_ff,
                  "result valid right after reset")

endmodule

// ===== tb/fixed_partition_allocator_unit_tb.sv =====
// self-checking testbench of the fixed partition allocator unit
`timescale 1ns / 1ps

module fixed_partition_allocator_unit_tb;
   import fpa_pkg::*;

   localparam int HOLES          = 64;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_TAIL     = 80;
   localparam int ITEM_TARGET    = 1900;
   localparam logic [POLICY_W-1:0] POL_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [IDX_W-1:0]    load_index;
      logic [SIZE_W-1:0]   size_value;
   } alloc_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    chosen_index;
      logic [SIZE_W-1:0]   chosen_size;
      logic [FRAG_W-1:0]   frag_amount;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POLICY;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   fpa_req_if req_bus ();
   fpa_rsp_if rsp_bus ();

   fixed_partition_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the hole table and registers
   logic [SIZE_W-1:0]   hole_size_copy [HOLES];
   logic                hole_taken_copy [HOLES];
   logic [POLICY_W-1:0] policy_cfg = POLICY_RESET;
   logic [COUNT_W-1:0]  hole_count_cfg = COUNT_RESET;

   // sizes as loaded by the stimulus, used to aim requests at real holes
   logic [SIZE_W-1:0] stim_sizes [HOLES];

   alloc_req_type pending_requests [$];
   alloc_rsp_type awaited_results [$];
   alloc_req_type offered_req;

   int items_queued    = 0;
   int mismatch_count  = 0;
   int cycles_run      = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int holdoff_requests = 0;
   int holdoff_served  = 0;
   int holdoff_left    = 0;
   int ready_mode      = 0;
   int ready_mode_left = 0;
   int ready_phase     = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_LOAD;
      req_bus.load_index = '0;
      req_bus.size_value = '0;
      rsp_bus.ready      = 1'b0;
      for (int i = 0; i < HOLES; i++) begin
         hole_size_copy[i]  = '0;
         hole_taken_copy[i] = 1'b0;
         stim_sizes[i]      = '0;
      end
   end

   function automatic alloc_rsp_type place_request(alloc_req_type r);
      alloc_rsp_type     res;
      int unsigned       span;
      int unsigned       i;
      int unsigned       pick;
      bit                found;
      bit                any_free;
      bit                better;
      logic [SIZE_W-1:0] diff;
      logic [SIZE_W-1:0] pick_diff;
      logic [FRAG_W:0]   free_sum;
      res       = '0;
      found     = 1'b0;
      any_free  = 1'b0;
      pick      = 0;
      pick_diff = '0;
      free_sum  = '0;
      if (r.opcode == OP_LOAD) begin
         hole_size_copy[r.load_index]  = r.size_value;
         hole_taken_copy[r.load_index] = 1'b0;
         res.status = ST_LOAD_DONE;
         return res;
      end
      span = (hole_count_cfg < HOLES) ? hole_count_cfg : HOLES;
      for (i = 0; i < span; i++) begin
         if (hole_taken_copy[i]) continue;
         any_free = 1'b1;
         free_sum = free_sum + hole_size_copy[i];
         if (free_sum > {1'b0, FRAG_MAX}) free_sum = {1'b0, FRAG_MAX};
         if (hole_size_copy[i] < r.size_value) continue;
         diff = hole_size_copy[i] - r.size_value;
         if (!found) begin
            better = 1'b1;
         end else if (policy_cfg == POL_BEST) begin
            better = diff < pick_diff;
         end else if (policy_cfg == POL_WORST) begin
            better = diff > pick_diff;
         end else begin
            better = 1'b0;
         end
         if (better) begin
            found     = 1'b1;
            pick      = i;
            pick_diff = diff;
         end
      end
      if (found) begin
         hole_taken_copy[pick] = 1'b1;
         res.status       = ST_ALLOCATED;
         res.chosen_index = pick[IDX_W-1:0];
         res.chosen_size  = hole_size_copy[pick];
         res.frag_amount  = FRAG_W'(pick_diff);
      end else if (any_free) begin
         res.status      = ST_NO_FIT;
         res.frag_amount = free_sum[FRAG_W-1:0];
      end else begin
         res.status = ST_NO_FREE;
      end
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_hole_size();
      logic [SIZE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = '0;
         1: s = '1;
         // few distinct sizes so that ties come up often
         2, 3, 4, 5: s = SIZE_W'($urandom_range(1, 8) * 64);
         6, 7: s = SIZE_W'($urandom_range(0, 4095));
         default: s = SIZE_W'($urandom);
      endcase
      return s;
   endfunction

   function automatic void queue_item(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] idx,
                                      logic [SIZE_W-1:0] size);
      alloc_req_type r;
      r.opcode     = op;
      r.load_index = idx;
      r.size_value = size;
      if (op == OP_LOAD) stim_sizes[idx] = size;
      pending_requests.push_back(r);
      items_queued++;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_sel,
                            input logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_sel;
      csr_wdata <= value;
      if (reg_sel == CSR_POLICY) begin
         policy_cfg = value[POLICY_W-1:0];
      end else begin
         hole_count_cfg = value[COUNT_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_bus.valid || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   // request driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            awaited_results.push_back(place_request(offered_req));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               offered_req = pending_requests.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.opcode     <= offered_req.opcode;
               req_bus.load_index <= offered_req.load_index;
               req_bus.size_value <= offered_req.size_value;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
      end
   end

   // response ready: changing stall patterns, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_served != holdoff_requests) begin
         holdoff_served++;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(50, 300);
         end else begin
            ready_mode_left--;
         end
         ready_phase = (ready_phase + 1) % 3;
         case (ready_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= (ready_phase != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected item status %0d index %0d size %0d frag %0d", $time,
                     rsp_bus.status, rsp_bus.chosen_index, rsp_bus.chosen_size,
                     rsp_bus.frag_amount);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.chosen_index !== want.chosen_index) begin
               $display("%0t: chosen_index expected %0d actual %0d", $time,
                        want.chosen_index, rsp_bus.chosen_index);
               mismatch_count++;
            end
            if (rsp_bus.chosen_size !== want.chosen_size) begin
               $display("%0t: chosen_size expected %0d actual %0d", $time,
                        want.chosen_size, rsp_bus.chosen_size);
               mismatch_count++;
            end
            if (rsp_bus.frag_amount !== want.frag_amount) begin
               $display("%0t: frag_amount expected %0d actual %0d", $time,
                        want.frag_amount, rsp_bus.frag_amount);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                  k;
      int                  phase_no;
      int                  gen_span;
      int                  n_load;
      int                  n_alloc;
      logic [SIZE_W-1:0]   base;
      logic [SIZE_W-1:0]   req_size;
      logic [POLICY_W-1:0] next_policy;
      logic [COUNT_W-1:0]  next_count;
      phase_no = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // clearing pass after reset: the block takes nothing until it is done
      for (k = 0; k < 4 * HOLES && req_bus.ready !== 1'b1; k++) @(negedge clock);

      // four holes, first fit: plain fit, zero request, exact fit at max, no fit, no free
      write_csr(CSR_HOLE_COUNT, 7'd4);
      write_csr(CSR_POLICY, CSR_DAT_W'(POL_FIRST));
      queue_item(OP_LOAD, 6'd0, 24'd100);
      queue_item(OP_LOAD, 6'd1, 24'd50);
      queue_item(OP_LOAD, 6'd2, 24'd100);
      queue_item(OP_LOAD, 6'd3, 24'hFFFFFF);
      queue_item(OP_ALLOC, 6'd0, 24'd50);
      queue_item(OP_ALLOC, 6'd0, 24'd0);
      queue_item(OP_ALLOC, 6'd0, 24'hFFFFFF);
      queue_item(OP_ALLOC, 6'd0, 24'd101);
      queue_item(OP_ALLOC, 6'd0, 24'd1);
      queue_item(OP_ALLOC, 6'd0, 24'd1);
      wait_for_drain();

      // best fit with exact-fit ties
      write_csr(CSR_POLICY, CSR_DAT_W'(POL_BEST));
      queue_item(OP_LOAD, 6'd0, 24'd100);
      queue_item(OP_LOAD, 6'd1, 24'd50);
      queue_item(OP_LOAD, 6'd2, 24'd100);
      queue_item(OP_LOAD, 6'd3, 24'd50);
      queue_item(OP_ALLOC, 6'd0, 24'd50);
      queue_item(OP_ALLOC, 6'd0, 24'd40);
      queue_item(OP_ALLOC, 6'd0, 24'd100);
      wait_for_drain();

      // worst fit, then a tie between equal holes
      write_csr(CSR_POLICY, CSR_DAT_W'(POL_WORST));
      queue_item(OP_LOAD, 6'd1, 24'd50);
      queue_item(OP_LOAD, 6'd3, 24'd50);
      queue_item(OP_ALLOC, 6'd0, 24'd10);
      queue_item(OP_ALLOC, 6'd0, 24'd50);
      wait_for_drain();

      // unknown policy acts as first fit; empty table; load past the count
      write_csr(CSR_POLICY, CSR_DAT_W'(POL_UNKNOWN));
      queue_item(OP_ALLOC, 6'd0, 24'd0);
      wait_for_drain();
      write_csr(CSR_HOLE_COUNT, 7'd0);
      queue_item(OP_ALLOC, 6'd0, 24'd5);
      queue_item(OP_LOAD, 6'd63, 24'd0);
      wait_for_drain();

      // fill the whole table so that no unwritten hole is ever scanned
      write_csr(CSR_HOLE_COUNT, COUNT_RESET);
      for (k = 0; k < HOLES; k++) queue_item(OP_LOAD, k[IDX_W-1:0], pick_hole_size());

      while (items_queued < ITEM_TARGET) begin
         phase_no++;
         if (phase_no <= 3 || $urandom_range(0, 2) == 0) begin
            wait_for_drain();
            case (phase_no)
               1: begin next_policy = POL_BEST;  next_count = 7'd1;   end
               2: begin next_policy = POL_WORST; next_count = 7'd127; end
               3: begin next_policy = POL_FIRST; next_count = COUNT_RESET; end
               default: begin
                  next_policy = POLICY_W'($urandom_range(0, 3));
                  case ($urandom_range(0, 11))
                     0: next_count = 7'd0;
                     1: next_count = 7'd1;
                     2, 3: next_count = COUNT_RESET;
                     4: next_count = COUNT_W'($urandom_range(65, 127));
                     default: next_count = COUNT_W'($urandom_range(2, 63));
                  endcase
               end
            endcase
            if (phase_no <= 3 || $urandom_range(0, 1))
               write_csr(CSR_POLICY, CSR_DAT_W'(next_policy));
            if (phase_no <= 3 || $urandom_range(0, 1)) write_csr(CSR_HOLE_COUNT, next_count);
         end
         gen_span = (hole_count_cfg < HOLES) ? hole_count_cfg : HOLES;
         if (gen_span == 0) gen_span = 1;

         // free some holes again, mostly inside the scanned range
         n_load = $urandom_range(0, 12);
         for (k = 0; k < n_load; k++) begin
            if ($urandom_range(0, 9) != 0)
               queue_item(OP_LOAD, IDX_W'($urandom_range(0, gen_span - 1)), pick_hole_size());
            else
               queue_item(OP_LOAD, IDX_W'($urandom_range(0, HOLES - 1)), pick_hole_size());
         end

         n_alloc = $urandom_range(4, 20);
         for (k = 0; k < n_alloc; k++) begin
            base = stim_sizes[$urandom_range(0, gen_span - 1)];
            case ($urandom_range(0, 9))
               0: req_size = '0;
               1: req_size = SIZE_W'($urandom);
               2: req_size = '1;
               3, 4: req_size = base;
               5: req_size = base + 1'b1;
               6: req_size = base - 1'b1;
               default: req_size = SIZE_W'($urandom_range(0, base));
            endcase
            queue_item(OP_ALLOC, IDX_W'($urandom), req_size);
            if ($urandom_range(0, 6) == 0)
               queue_item(OP_LOAD, IDX_W'($urandom_range(0, HOLES - 1)), pick_hole_size());
         end

         // receiver holds off while the sender keeps offering
         if (phase_no == 4 || phase_no == 30) holdoff_requests++;
         while (pending_requests.size() > 8) @(negedge clock);
      end

      wait_for_drain();
      repeat (DRAIN_TAIL) @(negedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
